// ===== rtl/three_phase_voice_oscillator_top_assert.svh =====
// assertion macros used by the checker file
`ifndef THREE_PHASE_VOICE_OSCILLATOR_TOP_ASSERT_SVH
`define THREE_PHASE_VOICE_OSCILLATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TPVO_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TPVO_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tpvo_pkg.sv =====
package tpvo_pkg;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE     = 3'd0,
        MUL_DS       = 3'd1,
        MUL_STEP     = 3'd2,
        MUL_SIN_MAIN = 3'd3,
        MUL_TRI      = 3'd4,
        MUL_SIN_SUB  = 3'd5,
        MUL_SIN_OCT  = 3'd6
    } mul_sel_t;

    // which accumulator addresses the sine rom
    typedef enum logic [1:0] {
        ROM_MAIN = 2'd0,
        ROM_SUB  = 2'd1,
        ROM_OCT  = 2'd2
    } rom_sel_t;

    // mix accumulator operation
    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_DRY  = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     phase_en;
        logic     rom_en;
        rom_sel_t rom_sel;
        acc_op_t  acc_op;
        logic     out_load;
    } cmd_t;

endpackage

// ===== rtl/tpvo_ctrl.sv =====
module tpvo_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output tpvo_pkg::cmd_t cmd
);
    import tpvo_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DS    = 10'b00_0000_0010,
        S_STEP  = 10'b00_0000_0100,
        S_ADV   = 10'b00_0000_1000,
        S_RD    = 10'b00_0001_0000,
        S_SIN_M = 10'b00_0010_0000,
        S_TRI   = 10'b00_0100_0000,
        S_SUB   = 10'b00_1000_0000,
        S_OCT   = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DS;
                end
            end
            S_DS:
            begin
                cmd.mul_sel = MUL_DS;
                state_next  = S_STEP;
            end
            S_STEP:
            begin
                cmd.mul_sel = MUL_STEP;
                state_next  = S_ADV;
            end
            S_ADV:
            begin
                cmd.phase_en = 1'b1;
                state_next   = S_RD;
            end
            S_RD:
            begin
                cmd.rom_en  = 1'b1;
                cmd.rom_sel = ROM_MAIN;
                state_next  = S_SIN_M;
            end
            S_SIN_M:
            begin
                cmd.mul_sel = MUL_SIN_MAIN;
                cmd.rom_en  = 1'b1;
                cmd.rom_sel = ROM_SUB;
                state_next  = S_TRI;
            end
            S_TRI:
            begin
                cmd.mul_sel = MUL_TRI;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_SUB;
            end
            S_SUB:
            begin
                cmd.mul_sel = MUL_SIN_SUB;
                cmd.acc_op  = ACC_ADD;
                cmd.rom_en  = 1'b1;
                cmd.rom_sel = ROM_OCT;
                state_next  = S_OCT;
            end
            S_OCT:
            begin
                cmd.mul_sel = MUL_SIN_OCT;
                cmd.acc_op  = ACC_DRY;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/tpvo_datapath.sv =====
module tpvo_datapath #(
    parameter int PHASE_BITS     = 24,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tpvo_pkg::cmd_t      cmd,
    input  logic                cfg_we,
    input  logic [23:0]         phase_step,
    input  logic signed [16:0]  timbre,
    input  logic [15:0]         drift_mult,
    input  logic signed [16:0]  weight_amount,
    input  logic signed [16:0]  shimmer_amount,
    input  logic [15:0]         swell_mult,
    output logic signed [16:0]  dry_sample,
    output logic signed [15:0]  shimmer_send
);
    import tpvo_pkg::*;

    localparam int QB          = SINE_ADDR_BITS - 2;
    localparam int QLEN        = 1 << QB;
    localparam int HALF_PI_Q30 = 1686629713;
    localparam logic [23:0] STEP_MASK =
        (PHASE_BITS >= 24) ? 24'hFF_FFFF : 24'((64'd1 << PHASE_BITS) - 64'd1);

    typedef logic [14:0] rom_t [QLEN + 1];

    // quarter-wave table, fixed Q30 taylor series up to x^13
    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int k = 0; k <= QLEN; k++)
        begin
            x    = (64'(HALF_PI_Q30) * 64'(k)) >> QB;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + term;
            v    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            r[k] = v[14:0];
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    function automatic logic [15:0] clamp_level(input logic signed [16:0] v);
        if (v < 17'sd0)
        begin
            return 16'd0;
        end
        else if (v > 17'sd32768)
        begin
            return 16'd32768;
        end
        return v[15:0];
    endfunction

    // divide by 2^15, rounding half up
    function automatic logic signed [19:0] round15(input logic signed [33:0] v);
        logic signed [34:0] w;
        w = 35'(v) + 35'sd16384;
        return 20'(w >>> 15);
    endfunction

    logic [23:0]            step_reg;
    logic [PHASE_BITS-1:0]  main_reg, sub_reg, oct_reg;
    logic [15:0]            t_reg, weight_reg, amount_reg;
    logic [15:0]            drift_reg, swell_reg;
    logic signed [57:0]     mul_reg;
    logic signed [33:0]     acc_reg;
    logic signed [16:0]     dry_reg;
    logic [14:0]            rom_reg;
    logic                   neg_reg;
    logic signed [16:0]     dry_out_reg;
    logic signed [15:0]     shim_out_reg;

    logic [55:0]            prod;
    logic [PHASE_BITS-1:0]  rom_phase;
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [QB:0]            rom_addr;
    logic signed [15:0]     sine;
    logic [14:0]            p15;
    logic signed [17:0]     tri_wide;
    logic signed [16:0]     tri_val;
    logic [15:0]            inv_t;
    logic signed [32:0]     mul_a;
    logic signed [24:0]     mul_b;
    logic signed [57:0]     mul_prod;
    logic signed [20:0]     dry_sum;
    logic signed [19:0]     shim_round;

    // --- config register and phase accumulators ---
    assign prod = mul_reg[55:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            main_reg <= '0;
            sub_reg  <= '0;
            oct_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= phase_step & STEP_MASK;
            end
            if (cmd.phase_en)
            begin
                main_reg <= main_reg + PHASE_BITS'(prod >> 28);
                sub_reg  <= sub_reg + PHASE_BITS'(prod >> 29);
                oct_reg  <= oct_reg + PHASE_BITS'(prod >> 27);
            end
        end
    end

    // --- sine rom lookup ---
    always_comb
    begin
        case (cmd.rom_sel)
            ROM_MAIN: rom_phase = main_reg;
            ROM_SUB:  rom_phase = sub_reg;
            ROM_OCT:  rom_phase = oct_reg;
            default:  rom_phase = main_reg;
        endcase
    end

    assign idx      = rom_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    // odd quadrants run the table backward
    assign rom_addr = idx[QB] ? ((QB+1)'(QLEN) - {1'b0, idx[QB-1:0]})
                              : {1'b0, idx[QB-1:0]};
    assign sine     = neg_reg ? -$signed({1'b0, rom_reg}) : $signed({1'b0, rom_reg});

    // --- triangle from the main phase ---
    assign p15      = main_reg[PHASE_BITS-1 -: 15];
    assign tri_wide = p15[14] ? (18'sd98304 - $signed({1'b0, p15, 2'b00}))
                              : ($signed({1'b0, p15, 2'b00}) - 18'sd32768);
    assign tri_val  = tri_wide[16:0];
    assign inv_t    = 16'(17'd32768 - {1'b0, t_reg});

    // --- shared multiplier ---
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_DS:
            begin
                mul_a = {17'd0, drift_reg};
                mul_b = {9'd0, swell_reg};
            end
            MUL_STEP:
            begin
                mul_a = {1'b0, mul_reg[31:0]};
                mul_b = {1'b0, step_reg};
            end
            MUL_SIN_MAIN:
            begin
                mul_a = {{17{sine[15]}}, sine};
                mul_b = {9'd0, inv_t};
            end
            MUL_TRI:
            begin
                mul_a = {{16{tri_val[16]}}, tri_val};
                mul_b = {9'd0, t_reg};
            end
            MUL_SIN_SUB:
            begin
                mul_a = {{17{sine[15]}}, sine};
                mul_b = {9'd0, weight_reg};
            end
            MUL_SIN_OCT:
            begin
                mul_a = {{17{sine[15]}}, sine};
                mul_b = {9'd0, amount_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod   = mul_a * mul_b;
    assign dry_sum    = 21'(round15(acc_reg)) + 21'(round15(mul_reg[33:0]));
    assign shim_round = round15(mul_reg[33:0]);

    // --- payload registers ---
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg      <= clamp_level(timbre);
            weight_reg <= clamp_level(weight_amount);
            amount_reg <= clamp_level(shimmer_amount);
            drift_reg  <= drift_mult;
            swell_reg  <= swell_mult;
        end
        if (cmd.mul_sel != MUL_NONE)
        begin
            mul_reg <= mul_prod;
        end
        if (cmd.rom_en)
        begin
            rom_reg <= SINE_ROM[rom_addr];
            neg_reg <= idx[QB+1];
        end
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= mul_reg[33:0];
            ACC_ADD:  acc_reg <= acc_reg + mul_reg[33:0];
            ACC_DRY:
            begin
                if (dry_sum > 21'sd65535)
                begin
                    dry_reg <= 17'sd65535;
                end
                else if (dry_sum < -21'sd65536)
                begin
                    dry_reg <= -17'sd65536;
                end
                else
                begin
                    dry_reg <= dry_sum[16:0];
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
        if (cmd.out_load)
        begin
            dry_out_reg <= dry_reg;
            if (shim_round > 20'sd32767)
            begin
                shim_out_reg <= 16'sd32767;
            end
            else if (shim_round < -20'sd32768)
            begin
                shim_out_reg <= -16'sd32768;
            end
            else
            begin
                shim_out_reg <= shim_round[15:0];
            end
        end
    end

    assign dry_sample   = dry_out_reg;
    assign shimmer_send = shim_out_reg;

endmodule

// ===== rtl/three_phase_voice_oscillator_top.sv =====
// three-phase voice oscillator: sine/triangle dds voice with sub and shimmer
// config channel: cfg_valid/cfg_ready with phase_step, always ready; write it
//   only while no request is in flight
// input channel: in_valid/in_ready carries one request of five control fields
// output channel: out_valid/out_ready carries dry_sample and shimmer_send
// one result per request; the result shows once the controller has run its
//   sequence and the output register is free
// one request at a time, taken only in idle, then run through the nine steps
//   of the controller sharing one 33x25 multiplier and one sine rom read port
// a new request is taken while the previous result still waits in the
//   output register; a stalled receiver holds the result and, once the next
//   result is done, blocks the input channel until it drains
// reset clears the phase accumulators, phase_step and out_valid
module three_phase_voice_oscillator_top #(
    parameter int PHASE_BITS     = 24,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        phase_step,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [16:0] timbre,
    input  logic [15:0]        drift_mult,
    input  logic signed [16:0] weight_amount,
    input  logic signed [16:0] shimmer_amount,
    input  logic [15:0]        swell_mult,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [16:0] dry_sample,
    output logic signed [15:0] shimmer_send
);
    import tpvo_pkg::*;

    cmd_t cmd;

    // user writes config only when idle (unchecked), so cfg need never stall
    assign cfg_ready = 1'b1;

    // controller: sequences the shared multiplier and rom, owns handshakes
    tpvo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath: phase accumulators, sine rom, multiplier, mix and output regs
    tpvo_datapath #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_valid & cfg_ready),
        .phase_step     (phase_step),
        .timbre         (timbre),
        .drift_mult     (drift_mult),
        .weight_amount  (weight_amount),
        .shimmer_amount (shimmer_amount),
        .swell_mult     (swell_mult),
        .dry_sample     (dry_sample),
        .shimmer_send   (shimmer_send)
    );

endmodule

// ===== rtl/tpvo_checker.sv =====
`include "three_phase_voice_oscillator_top_assert.svh"

module tpvo_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [16:0] dry_sample,
    input logic signed [15:0] shimmer_send
);

    // stalled result holds
    `TPVO_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(dry_sample) && $stable(shimmer_send), "stalled result changed")

    // busy right after a request is taken
    `TPVO_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")

    // still busy through the whole sequence
    `TPVO_ASSERT(a_busy_span, in_valid && in_ready, ##9 !in_ready, "request sequence ended early")

    // no result earlier than the sequence allows
    `TPVO_ASSERT(a_min_latency, in_valid && in_ready && !out_valid, ##9 !out_valid, "result appeared too early")

endmodule

bind three_phase_voice_oscillator_top tpvo_checker u_checker (.*);

// ===== bench/three_phase_voice_oscillator_top_tb.sv =====
`timescale 1ns / 1ps

module three_phase_voice_oscillator_top_tb;

    localparam int PHASE_BITS      = 24;
    localparam int SINE_ADDR_BITS  = 10;
    localparam int QUARTER_BITS    = SINE_ADDR_BITS - 2;
    localparam int QUARTER_LEN     = 1 << QUARTER_BITS;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int RANDOM_SAMPLES   = 700;
    localparam int LONG_HOLD_AT     = 200;   // results seen before the long receiver hold
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 40;    // margin after the last result, leave plenty
    localparam int CYCLE_LIMIT      = 400000;

    // what sits in the pending queue: an audio request, a phase_step write, or a
    // pause until every result is back
    typedef enum logic [1:0] {
        REQ_SAMPLE,
        REQ_CONFIG,
        REQ_DRAIN
    } req_kind_t;

    // receiver behavior while not in the long hold
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE
    } rx_mode_t;

    typedef struct packed {
        req_kind_t          kind;
        logic [23:0]        step;
        logic signed [16:0] timbre;
        logic [15:0]        drift;
        logic signed [16:0] weight;
        logic signed [16:0] shimmer;
        logic [15:0]        swell;
    } voice_req_t;

    typedef struct packed {
        logic signed [16:0] dry;
        logic signed [15:0] shimmer;
    } voice_out_t;

    // dut ports; every input is known from time zero
    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [23:0]        phase_step     = '0;
    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic signed [16:0] timbre         = '0;
    logic [15:0]        drift_mult     = '0;
    logic signed [16:0] weight_amount  = '0;
    logic signed [16:0] shimmer_amount = '0;
    logic [15:0]        swell_mult     = '0;
    logic               out_valid;
    logic               out_ready      = 1'b0;
    logic signed [16:0] dry_sample;
    logic signed [15:0] shimmer_send;

    // stimulus and scoreboard
    voice_req_t pending_reqs[$];
    voice_out_t expected_samples[$];
    voice_req_t cur_req;
    int         sent_count     = 0;
    int         recv_count     = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    // sender burst/gap shaping
    int gap_left   = 0;
    int burst_left = 1;

    // receiver stall shaping
    rx_mode_t rx_mode   = RX_FREE;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    // predictor state: accumulators and the step register, reset to zero
    logic [23:0] step_reg = '0;
    logic [23:0] main_acc = '0;
    logic [23:0] sub_acc  = '0;
    logic [23:0] oct_acc  = '0;
    int          quarter_rom [0:QUARTER_LEN];

    three_phase_voice_oscillator_top #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .phase_step     (phase_step),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .timbre         (timbre),
        .drift_mult     (drift_mult),
        .weight_amount  (weight_amount),
        .shimmer_amount (shimmer_amount),
        .swell_mult     (swell_mult),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .dry_sample     (dry_sample),
        .shimmer_send   (shimmer_send)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // quarter-wave entry: q30 taylor series up to x^13, each term truncated
    function automatic int quarter_sine(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned v;
        x    = (HALF_PI_Q30 * 64'(k)) >> QUARTER_BITS;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n < 13; n += 2)
        begin
            term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
            if (((n + 1) / 2) % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return int'(v);
    endfunction

    // full-cycle sine from the top address bits, no interpolation
    function automatic longint sine_at(logic [23:0] ph);
        logic [SINE_ADDR_BITS-1:0] idx;
        int                        k;
        idx = ph[PHASE_BITS-1 -: SINE_ADDR_BITS];
        k   = int'(idx[QUARTER_BITS-1:0]);
        case (idx[SINE_ADDR_BITS-1 -: 2])
            2'd0:    return  quarter_rom[k];
            2'd1:    return  quarter_rom[QUARTER_LEN - k];
            2'd2:    return -quarter_rom[k];
            default: return -quarter_rom[QUARTER_LEN - k];
        endcase
    endfunction

    // levels are clamped to 0.0..1.0 in q1.15
    function automatic longint level_q15(logic signed [16:0] raw);
        longint v;
        v = raw;
        if (v < 0)
            return 0;
        if (v > 32768)
            return 32768;
        return v;
    endfunction

    // divide by 2^15 rounding half up, floor via arithmetic shift
    function automatic longint round_q15(longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic longint saturate(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // steps the three accumulators and returns the sample that follows
    function automatic voice_out_t advance_voice(voice_req_t r);
        longint unsigned prod;
        longint          t;
        longint          w;
        longint          a;
        longint          p15;
        longint          tri_wave;
        longint          primary;
        longint          sub;
        voice_out_t      o;
        t    = level_q15(r.timbre);
        w    = level_q15(r.weight);
        a    = level_q15(r.shimmer);
        prod = 64'(step_reg) * 64'(r.drift) * 64'(r.swell);
        // phases advance before anything is looked up
        main_acc = main_acc + 24'(prod >> 28);
        sub_acc  = sub_acc  + 24'(prod >> 29);
        oct_acc  = oct_acc  + 24'(prod >> 27);
        p15      = longint'(main_acc >> (PHASE_BITS - 15));
        tri_wave = (p15 < 16384) ? (4 * p15 - 32768) : (98304 - 4 * p15);
        primary  = round_q15(sine_at(main_acc) * (32768 - t) + tri_wave * t);
        sub      = round_q15(sine_at(sub_acc) * w);
        o.dry     = 17'(saturate(primary + sub, -65536, 65535));
        o.shimmer = 16'(saturate(round_q15(sine_at(oct_acc) * a), -32768, 32767));
        return o;
    endfunction

    // random level: mostly in range, often at or past the clamp edges
    function automatic logic signed [16:0] pick_level();
        int edges [7] = '{0, 32768, 32767, 32769, -1, -65536, 65535};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 17'($urandom_range(0, 32768));
            6:                return 17'($urandom);
            7:                return 17'($urandom_range(32768, 65535));
            8:                return 17'(-int'($urandom_range(1, 65536)));
            default:          return 17'(edges[$urandom_range(0, 6)]);
        endcase
    endfunction

    // random q2.14 multiplier, mostly near unity
    function automatic logic [15:0] pick_mult();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 16'($urandom_range(12000, 24000));
            6, 7:             return 16'($urandom);
            8:                return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:          return 16'd16384;
        endcase
    endfunction

    task automatic queue_sample(logic signed [16:0] t, logic [15:0] d, logic signed [16:0] w,
                                logic signed [16:0] s, logic [15:0] sw);
        voice_req_t r;
        r         = '0;
        r.kind    = REQ_SAMPLE;
        r.timbre  = t;
        r.drift   = d;
        r.weight  = w;
        r.shimmer = s;
        r.swell   = sw;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_marker(req_kind_t kind, logic [23:0] step);
        voice_req_t r;
        r      = '0;
        r.kind = kind;
        r.step = step;
        pending_reqs.push_back(r);
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // driver: takes requests from the pending queue, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic       next_in;
        logic       next_cfg;
        voice_req_t head;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            // valid stays up until the request is taken
            next_in  = in_valid && !in_ready;
            next_cfg = cfg_valid && !cfg_ready;
            if (in_valid && in_ready)
            begin
                expected_samples.push_back(advance_voice(cur_req));
                sent_count <= sent_count + 1;
            end
            if (cfg_valid && cfg_ready)
                step_reg = phase_step;
            if (!next_in && !next_cfg)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() > 0)
                begin
                    head = pending_reqs[0];
                    case (head.kind)
                        REQ_SAMPLE:
                        begin
                            void'(pending_reqs.pop_front());
                            cur_req        = head;
                            timbre         <= head.timbre;
                            drift_mult     <= head.drift;
                            weight_amount  <= head.weight;
                            shimmer_amount <= head.shimmer;
                            swell_mult     <= head.swell;
                            next_in = 1'b1;
                            burst_left--;
                            if (burst_left <= 0)
                            begin
                                // end of burst: sometimes no gap at all
                                burst_left = $urandom_range(1, 40);
                                gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                         : $urandom_range(1, 25);
                            end
                        end
                        REQ_CONFIG:
                        begin
                            // only while idle: nothing offered, every result back
                            if (!in_valid && sent_count == recv_count)
                            begin
                                void'(pending_reqs.pop_front());
                                phase_step <= head.step;
                                next_cfg = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (!in_valid && sent_count == recv_count)
                                void'(pending_reqs.pop_front());
                        end
                    endcase
                end
            end
            in_valid  <= next_in;
            cfg_valid <= next_cfg;
        end
    end

    // monitor: compares each result with the oldest prediction, and shapes
    // out_ready with its own stall pattern plus one long hold
    always @(posedge clk or negedge rst_n)
    begin : check_results
        voice_out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                recv_count <= recv_count + 1;
                if (expected_samples.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want = expected_samples.pop_front();
                    if (dry_sample !== want.dry)
                        report_mismatch($sformatf("result %0d dry_sample %0d, want %0d",
                                                  recv_count, dry_sample, want.dry));
                    if (shimmer_send !== want.shimmer)
                        report_mismatch($sformatf("result %0d shimmer_send %0d, want %0d",
                                                  recv_count, shimmer_send, want.shimmer));
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && recv_count >= LONG_HOLD_AT)
            begin
                // long hold: the block backs up and must stall its input
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(30, 200);
                end
                else
                    mode_left--;
                case (rx_mode)
                    RX_FREE:  out_ready <= 1'b1;
                    RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
                    default:  out_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("three_phase_voice_oscillator_top verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic signed [16:0] levels [8];
        logic [15:0]        mults [8];
        logic [23:0]        steps [8];
        int                 per_phase;

        for (int k = 0; k <= QUARTER_LEN; k++)
            quarter_rom[k] = quarter_sine(k);

        levels = '{-17'sd65536, 17'sd65535, 17'sd0, 17'sd32768,
                   17'sd32767, 17'sd32769, -17'sd1, 17'sd16384};
        mults  = '{16'd0, 16'd65535, 16'd16384, 16'd1,
                   16'd32768, 16'd8192, 16'd65535, 16'd16384};

        // directed part at the largest step, so max multipliers wrap phases by
        // many turns per sample
        queue_marker(REQ_CONFIG, 24'hFFFFFF);
        for (int i = 0; i < 8; i++)
            queue_sample(levels[i], mults[i], levels[(i + 3) % 8], levels[(i + 5) % 8],
                         mults[(i + 2) % 8]);
        for (int i = 0; i < 3; i++)
            queue_sample(levels[i + 2], 16'hFFFF, levels[i + 3], levels[i + 4], 16'hFFFF);
        queue_sample(17'sd0, 16'd0, 17'sd32768, 17'sd32768, 16'd0);
        queue_sample(17'sd32768, 16'd0, 17'sd32768, 17'sd32768, 16'hFFFF);
        queue_sample(17'sd32768, 16'd16384, 17'sd32768, 17'sd32768, 16'd16384);
        queue_sample(-17'sd65536, 16'd16384, -17'sd65536, -17'sd65536, 16'd16384);
        queue_sample(17'sd65535, 16'd16383, 17'sd65535, 17'sd65535, 16'd16385);

        // random phases, each under its own step setting
        steps = '{24'd0, 24'd1, 24'd153791, 24'hFFFFFF, 24'd5000,
                  24'($urandom), 24'($urandom_range(1000, 400000)), 24'h800000};
        per_phase = RANDOM_SAMPLES / 8;
        for (int p = 0; p < 8; p++)
        begin
            queue_marker(REQ_CONFIG, steps[p]);
            for (int i = 0; i < per_phase; i++)
            begin
                // the sender pauses until all results are back, once for sure
                if ((p == 2 && i == per_phase / 2) || $urandom_range(0, 59) == 0)
                    queue_marker(REQ_DRAIN, '0);
                queue_sample(pick_level(), pick_mult(), pick_level(), pick_level(), pick_mult());
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // everything offered and taken, then everything back
        while (pending_reqs.size() != 0 || in_valid || cfg_valid)
            @(posedge clk);
        while (recv_count != sent_count)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_samples.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_samples.size()));
        if (mismatch_count == 0)
            $display("three_phase_voice_oscillator_top verification clean");
        else
            $display("three_phase_voice_oscillator_top verification failed");
        $finish;
    end

endmodule

// ===== three_phase_voice_oscillator_top.f =====
+incdir+rtl
rtl/tpvo_pkg.sv
rtl/tpvo_ctrl.sv
rtl/tpvo_datapath.sv
rtl/three_phase_voice_oscillator_top.sv
rtl/tpvo_checker.sv
bench/three_phase_voice_oscillator_top_tb.sv
